>>> rtl/ared_pkg.sv
`timescale 1ns / 1ps

package ared_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG     = 3'd3;

    localparam logic [1:0] MODE_MEAN_SQ = 2'd1;

    // Envelope and level formats.
    localparam int ENV_W   = 16;
    localparam int LEVEL_W = 17;
    localparam logic [LEVEL_W-1:0] LEVEL_FLOOR   = 17'h1A000;  // -96 dB in Q8.8
    localparam logic [15:0]        DB_FLOOR_MAG  = 16'd24576;
    localparam logic [31:0]        DB_PER_OCTAVE = 32'd394566; // 20*log10(2) in Q16

    // Log2 mantissa: Q1.30 held in 31 bits.
    localparam int LOG_M_W    = 31;
    localparam int LOG_FRAC   = 30;
    localparam int LOG_ITERS  = 16;
    localparam int NEG_L_W    = 21;

    // Shared digit-serial multiplier.
    localparam int MUL_W     = 32;
    localparam int MUL_DIG   = 4;
    localparam int MUL_STEPS = MUL_W / MUL_DIG;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [2*MUL_W-1:0] prod;
    } t_mul_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAG,
        S_SQ_WAIT,
        S_SMOOTH,
        S_TERM_WAIT,
        S_POST,
        S_NORM,
        S_LSQ,
        S_LSQ_WAIT,
        S_DB,
        S_DB_WAIT,
        S_FINISH
    } t_state;

endpackage

>>> rtl/ared_serial_mul.sv
`timescale 1ns / 1ps

module ared_serial_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ared_pkg::t_mul_req i_req,
    output ared_pkg::t_mul_rsp o_rsp
);
    import ared_pkg::*;

    logic [MUL_W-1:0]         r_a;
    logic [MUL_W-1:0]         r_b;
    logic [2*MUL_W-1:0]       r_acc;
    logic [MUL_CNT_W-1:0]     r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [MUL_W+MUL_DIG-1:0] pp;
    logic [MUL_W+MUL_DIG-1:0] sum_hi;

    // One multiplier digit per cycle; the accumulator shifts right by a digit.
    assign pp     = (MUL_W+MUL_DIG)'(r_a) * (MUL_W+MUL_DIG)'(r_b[MUL_DIG-1:0]);
    assign sum_hi = (MUL_W+MUL_DIG)'(r_acc[2*MUL_W-1:MUL_W]) + pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= {sum_hi, r_acc[MUL_W-1:MUL_DIG]};
                r_b   <= r_b >> MUL_DIG;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

>>> rtl/attack_release_envelope_detector.sv
`timescale 1ns / 1ps
// Attack/release envelope detector for signed audio samples.
//
// Input channel: i_sample with i_in_valid / o_in_stall. A transfer happens on a
// rising edge with valid high and stall low. Output channel: o_level with
// o_out_valid / i_out_stall, one result per input sample, held in an output
// register so the next sample can be taken while a result waits.
//
// The block works on one sample at a time; one shared multiplier handles one
// 4-bit digit per cycle. Linear output needs one product per sample in peak
// and RMS mode and two in mean square mode, where the magnitude is squared
// first. In dB mode a nonzero envelope adds bit-at-a-time normalization, 16
// mantissa squarings and one more product for the dB scaling.
//
// Reset (synchronous, active low) clears the envelope, all configuration
// registers and the output valid flag. Configuration is written through
// i_cfg_we / i_cfg_index / i_cfg_data; indexes past the last register are
// ignored. When the receiver stalls, a finished result waits in the core
// until the output register frees up; o_in_stall stays high meanwhile.
module attack_release_envelope_detector #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ared_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ared_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ared_pkg::LEVEL_W-1:0] o_level
);
    import ared_pkg::*;

    localparam int PK_W = SAMPLE_BITS + 17;
    localparam int MS_W = 2 * SAMPLE_BITS + 18;

    // Configuration registers.
    logic [15:0] r_attack;
    logic [15:0] r_release;
    logic [1:0]  r_mode;
    logic        r_log;

    // Sequencer state and datapath registers.
    t_state               r_state, n_state;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [ENV_W-1:0]     r_det, n_det;
    logic [ENV_W-1:0]     r_env, n_env;
    logic                 r_up, n_up;
    logic [LOG_M_W-1:0]   r_m, n_m;
    logic [3:0]           r_p, n_p;
    logic [15:0]          r_frac, n_frac;
    logic [3:0]           r_it, n_it;
    logic [LEVEL_W-1:0]   r_level, n_level;
    logic                 r_out_valid;
    logic [LEVEL_W-1:0]   r_out_level;
    logic                 out_load;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    // Combinational helpers.
    logic [SAMPLE_BITS-1:0] in_u;
    logic [SAMPLE_BITS-1:0] in_mag;
    logic [PK_W-1:0]        pk_w;
    logic [ENV_W-1:0]       pk_det;
    logic [MS_W-1:0]        ms_w;
    logic [ENV_W-1:0]       ms_det;
    logic [32:0]            term_sum;
    logic [16:0]            term;
    logic [18:0]            env_next;
    logic [ENV_W-1:0]       env_clamped;
    logic [MUL_W-1:0]       sq_v;
    logic [NEG_L_W-1:0]     neg_l;
    logic [39:0]            db_sum;
    logic [15:0]            db;

    ared_serial_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_rsp  (mul_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= '0;
            r_release <= '0;
            r_mode    <= '0;
            r_log     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ATTACK:  r_attack  <= i_cfg_data;
                CFG_RELEASE: r_release <= i_cfg_data;
                CFG_MODE:    r_mode    <= i_cfg_data[1:0];
                CFG_LOG:     r_log     <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Magnitude of the incoming sample; full-scale negative maps to 2^(N-1).
    assign in_u   = SAMPLE_BITS'(i_sample);
    assign in_mag = i_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~in_u + 1'b1) : in_u;

    // Scale the magnitude to Q0.16 (truncating) and saturate at full scale.
    assign pk_w   = {r_mag, 17'd0} >> SAMPLE_BITS;
    assign pk_det = (pk_w[PK_W-1:16] != '0) ? 16'hFFFF : pk_w[15:0];

    // Scale the square to Q0.16 in the same way.
    assign ms_w   = {mul_rsp.prod[2*SAMPLE_BITS-1:0], 18'd0} >> (2 * SAMPLE_BITS);
    assign ms_det = (ms_w[MS_W-1:16] != '0) ? 16'hFFFF : ms_w[15:0];

    // Rounded smoothing term and the clamped new envelope.
    assign term_sum = mul_rsp.prod[32:0] + 33'd32768;
    assign term     = term_sum[32:16];
    assign env_next = r_up ? ({3'b000, r_det} - {2'b00, term})
                           : ({3'b000, r_det} + {2'b00, term});
    always_comb begin
        if (env_next[18]) begin
            env_clamped = '0;
        end else if (env_next[17:16] != 2'b00) begin
            env_clamped = 16'hFFFF;
        end else begin
            env_clamped = env_next[15:0];
        end
    end

    // Squared mantissa back in Q1.30, one bit wider before renormalizing.
    assign sq_v = mul_rsp.prod[2*LOG_FRAC+1:LOG_FRAC];

    // Distance below full scale in octaves, Q16, and its rounded dB value.
    assign neg_l  = NEG_L_W'(21'd1 << 20) - NEG_L_W'({r_p, r_frac});
    assign db_sum = mul_rsp.prod[39:0] + 40'd8388608;
    assign db     = db_sum[39:24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_env   <= '0;
        end else begin
            r_state <= n_state;
            r_env   <= n_env;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_mag <= in_mag;
        end
        r_det   <= n_det;
        r_up    <= n_up;
        r_m     <= n_m;
        r_p     <= n_p;
        r_frac  <= n_frac;
        r_it    <= n_it;
        r_level <= n_level;
    end

    always_comb begin
        n_state  = r_state;
        n_det    = r_det;
        n_env    = r_env;
        n_up     = r_up;
        n_m      = r_m;
        n_p      = r_p;
        n_frac   = r_frac;
        n_it     = r_it;
        n_level  = r_level;
        out_load = 1'b0;
        mul_req  = '{start: 1'b0, a: '0, b: '0};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                if (r_mode == MODE_MEAN_SQ) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_W'(r_mag);
                    mul_req.b     = MUL_W'(r_mag);
                    n_state       = S_SQ_WAIT;
                end else begin
                    // Peak, RMS and the unused code all take the magnitude.
                    n_det   = pk_det;
                    n_state = S_SMOOTH;
                end
            end
            S_SQ_WAIT: begin
                if (mul_rsp.done) begin
                    n_det   = ms_det;
                    n_state = S_SMOOTH;
                end
            end
            S_SMOOTH: begin
                mul_req.start = 1'b1;
                if (r_det > r_env) begin
                    n_up      = 1'b1;
                    mul_req.a = MUL_W'(r_attack);
                    mul_req.b = MUL_W'(r_det - r_env);
                end else begin
                    n_up      = 1'b0;
                    mul_req.a = MUL_W'(r_release);
                    mul_req.b = MUL_W'(r_env - r_det);
                end
                n_state = S_TERM_WAIT;
            end
            S_TERM_WAIT: begin
                if (mul_rsp.done) begin
                    n_env   = env_clamped;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (!r_log) begin
                    n_level = {1'b0, r_env};
                    n_state = S_FINISH;
                end else if (r_env == '0) begin
                    n_level = LEVEL_FLOOR;
                    n_state = S_FINISH;
                end else begin
                    n_m     = {r_env, 15'd0};
                    n_p     = 4'd15;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                // Shift one place per cycle until the leading one sits at bit 30.
                if (r_m[LOG_M_W-1]) begin
                    n_it    = '0;
                    n_state = S_LSQ;
                end else begin
                    n_m = {r_m[LOG_M_W-2:0], 1'b0};
                    n_p = r_p - 1'b1;
                end
            end
            S_LSQ: begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_W'(r_m);
                mul_req.b     = MUL_W'(r_m);
                n_state       = S_LSQ_WAIT;
            end
            S_LSQ_WAIT: begin
                if (mul_rsp.done) begin
                    // A square of 2.0 or more gives a one in this fraction bit.
                    n_m    = sq_v[MUL_W-1] ? sq_v[MUL_W-1:1] : sq_v[LOG_M_W-1:0];
                    n_frac = {r_frac[14:0], sq_v[MUL_W-1]};
                    n_it   = r_it + 1'b1;
                    if (r_it == 4'(LOG_ITERS - 1)) begin
                        n_state = S_DB;
                    end else begin
                        n_state = S_LSQ;
                    end
                end
            end
            S_DB: begin
                mul_req.start = 1'b1;
                mul_req.a     = DB_PER_OCTAVE;
                mul_req.b     = MUL_W'(neg_l);
                n_state       = S_DB_WAIT;
            end
            S_DB_WAIT: begin
                if (mul_rsp.done) begin
                    if (db > DB_FLOOR_MAG) begin
                        n_level = LEVEL_FLOOR;
                    end else begin
                        n_level = LEVEL_W'(0) - {1'b0, db};
                    end
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: loaded from the core, emptied by an output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_level <= r_level;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_level     = $signed(r_out_level);

    // A new result only appears after the sequencer has finished an item.
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("output valid rose without a finished item");

    // The shared multiplier is never restarted while it is still working.
    a_mul_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier started while busy");

    // Normalization only runs on a nonzero mantissa, so it always ends.
    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_m != '0))
        else $error("normalizing a zero envelope");

    // A product is reported only at the end of a busy run.
    a_mul_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> $past(mul_rsp.busy))
        else $error("multiplier done without a busy run");

endmodule

>>> bench/attack_release_envelope_detector_test.sv
`timescale 1ns / 1ps

module attack_release_envelope_detector_test;

    import ared_pkg::*;

    localparam int SAMPLE_W = 16;

    // Detect modes that the package leaves unnamed.
    localparam logic [1:0] MODE_PEAK  = 2'd0;
    localparam logic [1:0] MODE_RMS   = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Indexes past the last register; writes to them must be ignored.
    localparam int FIRST_SPARE_IDX = 4;
    localparam int LAST_SPARE_IDX  = (1 << CFG_IDX_W) - 1;

    localparam longint DB_FLOOR_Q88 = -24576;
    localparam longint ENV_TOP      = 65535;

    // Scoreboard: it tracks the envelope and the register file on its own, works out
    // the level that each accepted sample must produce, and checks the results in order.
    class level_scoreboard;
        logic [15:0]        atk_coeff;
        logic [15:0]        rel_coeff;
        logic [1:0]         mode;
        logic               log_on;
        logic [15:0]        env;
        logic signed [16:0] expected_levels[$];
        int                 errors;
        int                 checked;

        function new();
            atk_coeff = '0;
            rel_coeff = '0;
            mode      = MODE_PEAK;
            log_on    = 1'b0;
            env       = '0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ATTACK:  atk_coeff = data[15:0];
                CFG_RELEASE: rel_coeff = data[15:0];
                CFG_MODE:    mode      = data[1:0];
                CFG_LOG:     log_on    = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        // log2 of a nonzero envelope in Q16: the exponent plus sixteen fraction bits
        // found by repeated squaring of a Q1.30 mantissa, truncating each step.
        function longint octave_log2(logic [15:0] v);
            int          p;
            logic [63:0] m;
            longint      frac;
            p = 0;
            while (p < 15 && (v >> (p + 1)) != 0)
                p++;
            m = 64'(v) << (30 - p);
            frac = 0;
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= 64'h8000_0000) begin
                    m = m >> 1;
                    frac = frac | 1;
                end
            end
            return (longint'(p) << 16) | frac;
        endfunction

        // Moves the envelope one sample forward and returns the level it shows.
        function logic signed [16:0] next_level(logic signed [SAMPLE_W-1:0] s);
            longint mag;
            longint det;
            longint cur;
            longint coeff;
            longint diff;
            longint term;
            longint nxt;
            longint neg_l;
            longint lvl;
            mag = s;
            if (mag < 0)
                mag = -mag;
            if (mode == MODE_MEAN_SQ)
                det = (mag * mag) >> 14;
            else
                det = mag << 1;
            if (det > ENV_TOP)
                det = ENV_TOP;
            cur = env;
            if (det > cur) begin
                coeff = atk_coeff;
                diff  = det - cur;
            end else begin
                coeff = rel_coeff;
                diff  = cur - det;
            end
            term = (coeff * diff + 32768) >> 16;
            nxt  = (det > cur) ? det - term : det + term;
            if (nxt < 0)
                nxt = 0;
            if (nxt > ENV_TOP)
                nxt = ENV_TOP;
            env = nxt[15:0];
            if (!log_on) begin
                lvl = env;
            end else if (env == 0) begin
                lvl = DB_FLOOR_Q88;
            end else begin
                neg_l = (longint'(16) << 16) - octave_log2(env);
                lvl = -((longint'(DB_PER_OCTAVE) * neg_l + (longint'(1) << 23)) >> 24);
                if (lvl < DB_FLOOR_Q88)
                    lvl = DB_FLOOR_Q88;
            end
            return lvl[16:0];
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            expected_levels.push_back(next_level(s));
        endfunction

        function void check_level(logic signed [16:0] actual);
            logic signed [16:0] want;
            checked++;
            if (expected_levels.size() == 0) begin
                $error("level: result with nothing pending, actual %0d", actual);
                errors++;
                return;
            end
            want = expected_levels.pop_front();
            if (actual !== want) begin
                $error("level mismatch: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic signed [SAMPLE_W-1:0]  i_sample;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [LEVEL_W-1:0]   o_level;

    level_scoreboard sb;

    // Idling controls, set per phase by the stimulus process. In the quiet stretch
    // at the end neither side idles.
    bit quiet;
    int gap_pct;
    int stall_pct;

    int n_sent;
    int n_settings;

    attack_release_envelope_detector #(
        .SAMPLE_BITS(SAMPLE_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_level     (o_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The whole run is far shorter than this even with every sample in dB mode
    // and both sides idling as much as they can.
    initial begin
        #(8_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    // Output monitor. It samples at the rising edge, before the block's own
    // registers update, so the handshake it sees is the one that completes there.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_level(o_level);
    end

    // Receiver: stalls come in random bursts, separated by open stretches.
    initial begin
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    // One sample transfer. It is called at a falling edge, holds the sample until
    // the block takes it, and returns at the falling edge after the transfer.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(s);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // The sender stops until every pending level has come back. Every sample
    // produces exactly one level, so the block is idle once the queue is empty.
    task automatic pause_for_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Writes all four registers. The bits above the mode and log fields carry random
    // values that the block must drop, and an optional write to an unused index must
    // change nothing.
    task automatic configure(input logic [15:0] atk, input logic [15:0] rel,
                             input logic [1:0] mode, input logic lg, input bit spare);
        write_reg(CFG_ATTACK, atk);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_MODE, {14'($urandom), mode});
        write_reg(CFG_LOG, {15'($urandom), lg});
        if (spare)
            write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_IDX, LAST_SPARE_IDX)),
                      CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Coefficients lean on the two ends: zero makes the envelope jump to the
    // detected value, the top value gives the slowest pole.
    function automatic logic [15:0] pick_coeff();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            4:       return 16'($urandom_range(60000, 65535));
            5:       return 16'($urandom_range(1, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sd0;
            3, 4:    return 16'($signed($urandom_range(0, 511)) - 256);
            5:       return 16'($urandom_range(24000, 32767));
            6:       return 16'(-$signed($urandom_range(24000, 32768)));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    initial begin
        int ph;
        int k;
        sb = new();
        quiet      = 1'b0;
        gap_pct    = 30;
        stall_pct  = 30;
        n_sent     = 0;
        n_settings = 0;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_sample    <= '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. First the reset settings: peak detection, zero
        // coefficients and linear output, so each level is the detected value.
        send_sample(16'sd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd0);
        pause_for_results();

        // Mean square with a half-speed attack and the slowest release; full-scale
        // negative saturates the square at one.
        configure(16'h8000, 16'hFFFF, MODE_MEAN_SQ, 1'b0, 1'b0);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sd181);
        send_sample(16'sd0);
        send_sample(16'sd0);
        pause_for_results();

        // The unused mode behaves as peak. In dB mode a zero envelope sits on the
        // floor and full scale reads 0 dB.
        configure(16'h0000, 16'h0000, MODE_SPARE, 1'b1, 1'b0);
        send_sample(16'sd0);
        send_sample(16'sh8000);
        send_sample(16'sd1);
        send_sample(16'sd100);
        send_sample(16'sd0);
        pause_for_results();

        // RMS mode with a write to an unused index in between.
        configure(16'hFFFF, 16'h0100, MODE_RMS, 1'b1, 1'b1);
        send_sample(16'sd20000);
        send_sample(-16'sd20000);
        send_sample(16'sd5);
        pause_for_results();

        // Random part: sixteen settings of a hundred samples each. Idling differs
        // from phase to phase, and the last two phases run with none at all.
        for (ph = 0; ph < 16; ph++) begin
            quiet     = (ph >= 14);
            gap_pct   = quiet ? 0 : pick_pct();
            stall_pct = quiet ? 0 : pick_pct();
            configure(pick_coeff(), pick_coeff(), 2'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
            for (k = 0; k < 100; k++) begin
                // Once in the middle of a phase the sender holds off until the
                // block has handed back everything it owes.
                if (ph == 6 && k == 50)
                    pause_for_results();
                send_sample(pick_sample());
                if ($urandom_range(0, 99) < gap_pct)
                    idle_sender($urandom_range(1, 6));
            end
            pause_for_results();
        end

        // Nothing is pending now; watch a while longer for any stray result.
        repeat (40) @(negedge i_clk);

        $display("Sent %0d samples under %0d register settings and checked %0d levels,",
                 n_sent, n_settings, sb.checked);
        $display("covering all detect modes, linear and dB output, and both stall sides.");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
